>>> src/ic_pkg.sv
package ic_pkg;

   localparam int KEY_W   = 32;
   localparam int TOTAL_W = 19;

   localparam logic [KEY_W-1:0]   SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // One item travelling down the chain.
   // drop:   item arrived with the chain full; it neither counts nor stores
   // placed: item already took a free cell
   typedef struct packed {
      logic             vld;
      logic             last;
      logic             drop;
      logic             placed;
      logic [KEY_W-1:0] key;
   } ic_token_type;

endpackage

>>> src/ic_req_if.sv
interface ic_req_if
   import ic_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] value;
   logic                    last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

>>> src/ic_rsp_if.sv
interface ic_rsp_if
   import ic_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] inversions;
   logic               overflow;

   modport source (output valid, output inversions, output overflow, input ready);
   modport sink   (input valid, input inversions, input overflow, output ready);
endinterface

>>> src/ic_cell.sv
module ic_cell
   import ic_pkg::*;
#(
   parameter int CNT_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  ic_token_type     up_tok,
   input  logic [CNT_W-1:0] up_cnt,
   output ic_token_type     dn_tok,
   output logic [CNT_W-1:0] dn_cnt
);

   logic             occ_ff, occ_in;
   logic [KEY_W-1:0] val_ff, val_in;
   ic_token_type     tok_ff, tok_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic live;
   logic greater;
   logic store;

   always_comb begin
      live    = up_tok.vld && !up_tok.drop;
      greater = live && occ_ff && (val_ff > up_tok.key);
      // first free cell takes the item; the last item is never stored, it only counts and clears
      store   = live && !up_tok.placed && !up_tok.last && !occ_ff;

      tok_in        = up_tok;
      tok_in.placed = up_tok.placed | store;
      cnt_in        = up_cnt + CNT_W'(greater);

      occ_in = occ_ff;
      val_in = val_ff;
      if (store) begin
         occ_in = 1'b1;
         val_in = up_tok.key;
      end
      // end of sequence: empty the cell behind the last item
      if (up_tok.vld && up_tok.last) begin
         occ_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
         occ_ff     <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         val_ff <= val_in;
         cnt_ff <= cnt_in;
      end
   end

   assign dn_tok = tok_ff;
   assign dn_cnt = cnt_ff;

endmodule

>>> src/inversion_counter.sv
// Streaming inversion counter.
// req_ch carries one signed value per item plus a last flag; rsp_ch returns
// one item per sequence holding the inversion total (saturating) and an
// overflow flag set when items beyond MAX_ITEMS were ignored.
// Both channels use valid/ready; an item moves when both are high.
// Values run down a row of MAX_ITEMS cells, one cell per cycle unless the
// row is stalled. Each cell holds one stored value, counts it if it is
// greater than the passing value, and the first empty cell keeps the value.
// A new item can enter every cycle unless the row is stalled. The total
// for a sequence is registered for rsp_ch when its last item leaves the row.
// The last item empties each cell as it passes, so the next sequence may
// follow right behind it.
// Reset empties all cells and drops any pending result.
// When a result waits in the output register and rsp_ch.ready is low, the
// next finished sequence stalls the whole row and req_ch.ready drops until
// the waiting result is taken.
module inversion_counter
   import ic_pkg::*;
#(
   parameter int MAX_ITEMS = 1024
) (
   input  logic clock,
   input  logic reset,
   ic_req_if.sink   req_ch,
   ic_rsp_if.source rsp_ch
);

   localparam int CNT_W  = $clog2(MAX_ITEMS);
   localparam int FILL_W = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W  = TOTAL_W + 1;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_ITEMS);

   ic_token_type     tok [0:MAX_ITEMS];
   logic [CNT_W-1:0] cnt [0:MAX_ITEMS];

   logic              advance;
   logic              req_take;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_inv_ff, rsp_inv_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   ic_token_type       tail_tok;
   logic [SUM_W-1:0]   sum;
   logic [TOTAL_W-1:0] total_nx;
   logic               ovf_nx;

   assign tail_tok = tok[MAX_ITEMS];

   // hold the row while a finished sequence cannot enter the output register
   assign advance  = !(tail_tok.vld && tail_tok.last && rsp_valid_ff && !rsp_ch.ready);
   assign req_take = req_ch.valid && advance;
   assign req_ch.ready = advance;

   always_comb begin
      tok[0].vld    = req_take;
      tok[0].last   = req_ch.last;
      tok[0].drop   = (fill_ff == FILL_MAX);
      tok[0].placed = 1'b0;
      tok[0].key    = req_ch.value ^ SIGN_FLIP;
      cnt[0]        = '0;
   end

   generate
      for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
         ic_cell #(.CNT_W(CNT_W)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .up_tok  (tok[i]),
            .up_cnt  (cnt[i]),
            .dn_tok  (tok[i+1]),
            .dn_cnt  (cnt[i+1])
         );
      end
   endgenerate

   always_comb begin
      fill_in = fill_ff;
      if (req_take) begin
         if (req_ch.last) begin
            fill_in = '0;
         end else if (fill_ff != FILL_MAX) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end

      sum = {1'b0, total_ff} + SUM_W'(cnt[MAX_ITEMS]);
      total_nx = total_ff;
      ovf_nx   = ovf_ff;
      if (tail_tok.vld) begin
         if (tail_tok.drop) begin
            ovf_nx = 1'b1;
         end else begin
            total_nx = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
         end
      end

      total_in     = total_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_inv_in   = rsp_inv_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (advance && tail_tok.vld) begin
         if (tail_tok.last) begin
            total_in     = '0;
            ovf_in       = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_inv_in   = total_nx;
            rsp_ovf_in   = ovf_nx;
         end else begin
            total_in = total_nx;
            ovf_in   = ovf_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inv_ff <= rsp_inv_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.inversions = rsp_inv_ff;
   assign rsp_ch.overflow   = rsp_ovf_ff;

endmodule

>>> src/ic_checker.sv
module ic_checker
   import ic_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [TOTAL_W-1:0] rsp_inversions,
   input logic               rsp_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_inversions) && $stable(rsp_overflow))
      else $error("result changed while stalled");

   // input side only backs up behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a waiting result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind inversion_counter ic_checker u_ic_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_inversions (rsp_ch.inversions),
   .rsp_overflow   (rsp_ch.overflow)
);

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import ic_pkg::*;

   localparam int CELLS = 1024;

   typedef struct {
      logic [TOTAL_W-1:0] inversions;
      logic               overflow;
   } total_type;

   typedef struct {
      logic signed [KEY_W-1:0] value;
      logic                    last;
      bit                      known;
      logic [TOTAL_W-1:0]      inversions;
      logic                    overflow;
   } plan_row_type;

   typedef enum int {SPREAD_ANY, SPREAD_NARROW, SPREAD_CORNER} spread_type;

   logic clock;
   logic reset;

   ic_req_if req_if();
   ic_rsp_if rsp_if();

   inversion_counter #(.MAX_ITEMS(CELLS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // predictor state
   logic signed [KEY_W-1:0] seq_vals[$];
   int unsigned             acc_total;
   bit                      cap_hit;

   total_type    pending_totals[$];
   plan_row_type plan [0:24];

   bit idle_on = 1'b1;
   int fail_count = 0;
   int items_sent = 0;
   int totals_seen = 0;
   int hold_cnt = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb_top: errors");
      $finish;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Count stored values above v, store v, emit the total on the last item.
   function automatic bit tally_value(input logic signed [KEY_W-1:0] v, input logic l,
                                      output logic [TOTAL_W-1:0] inv, output logic ovf);
      int unsigned above;
      above = 0;
      inv = '0;
      ovf = 1'b0;
      if (seq_vals.size() < CELLS) begin
         foreach (seq_vals[k])
            if (seq_vals[k] > v) above++;
         acc_total = acc_total + above;
         if (acc_total > int'(TOTAL_MAX)) acc_total = int'(TOTAL_MAX);
         seq_vals.push_back(v);
      end else begin
         cap_hit = 1'b1;
      end
      if (!l) return 1'b0;
      inv = acc_total[TOTAL_W-1:0];
      ovf = cap_hit;
      seq_vals.delete();
      acc_total = 0;
      cap_hit = 1'b0;
      return 1'b1;
   endfunction

   task automatic offer_value(input logic signed [KEY_W-1:0] v, input logic l,
                              input bit known, input logic [TOTAL_W-1:0] k_inv,
                              input logic k_ovf);
      total_type          want;
      logic [TOTAL_W-1:0] inv;
      logic               ovf;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= v;
      req_if.last  <= l;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      if (tally_value(v, l, inv, ovf)) begin
         want.inversions = known ? k_inv : inv;
         want.overflow   = known ? k_ovf : ovf;
         pending_totals.push_back(want);
      end
   endtask

   function automatic logic signed [KEY_W-1:0] pick_value(input spread_type mode);
      case (mode)
         SPREAD_ANY:    return $urandom;
         SPREAD_NARROW: return int'($urandom_range(0, 8)) - 4;
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return -1;
               3:       return 0;
               default: return 1;
            endcase
         end
      endcase
   endfunction

   task automatic send_short_runs(input int budget);
      int         sent;
      int         len;
      spread_type mode;
      sent = 0;
      while (sent < budget) begin
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         mode = spread_type'($urandom_range(0, 2));
         for (int i = 1; i <= len; i++)
            offer_value(pick_value(mode), i == len, 1'b0, '0, 1'b0);
         sent += len;
      end
   endtask

   // Fill every cell with a falling run, then push past capacity; the last two items are dropped.
   task automatic send_full_run();
      longint level;
      level = 64'sd2147483647;
      for (int i = 1; i <= CELLS + 2; i++) begin
         if (i <= CELLS) begin
            offer_value(KEY_W'(level), 1'b0 || i == CELLS + 2, 1'b0, '0, 1'b0);
            level -= $urandom_range(1, 4_000_000);
         end else begin
            offer_value($urandom, i == CELLS + 2, 1'b0, '0, 1'b0);
         end
      end
   endtask

   // rsp side: check accepted items, stall ready in short bursts
   always @(posedge clock) begin
      total_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         totals_seen++;
         if (pending_totals.size() == 0) begin
            flag_mismatch("unexpected total", rsp_if.inversions, -1);
         end else begin
            want = pending_totals.pop_front();
            if (rsp_if.inversions !== want.inversions)
               flag_mismatch("inversions", rsp_if.inversions, want.inversions);
            if (rsp_if.overflow !== want.overflow)
               flag_mismatch("overflow", rsp_if.overflow, want.overflow);
         end
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         hold_cnt = $urandom_range(1, 5) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.value = '0;
      req_if.last  = 1'b0;
      rsp_if.ready = 1'b0;
      acc_total    = 0;
      cap_hit      = 1'b0;

      plan = '{
         '{32'sh7FFF_FFFF, 1'b1, 1'b1, 19'd0, 1'b0},
         '{32'sh8000_0000, 1'b1, 1'b1, 19'd0, 1'b0},
         '{32'sh0000_0000, 1'b1, 1'b1, 19'd0, 1'b0},
         '{32'sh7FFF_FFFF, 1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sh8000_0000, 1'b1, 1'b1, 19'd1, 1'b0},
         '{32'sh8000_0000, 1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sh7FFF_FFFF, 1'b1, 1'b1, 19'd0, 1'b0},
         '{32'sd5,         1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sd5,         1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sd5,         1'b1, 1'b1, 19'd0, 1'b0},
         '{32'sd3,         1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sd2,         1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sd1,         1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sd0,         1'b1, 1'b1, 19'd6, 1'b0},
         '{-32'sd1,        1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sd1,         1'b0, 1'b0, 19'd0, 1'b0},
         '{-32'sd1,        1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sd0,         1'b1, 1'b0, 19'd0, 1'b0},
         '{32'shFFFF_FFFF, 1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sh0000_0000, 1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sh8000_0001, 1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sh7FFF_FFFE, 1'b1, 1'b0, 19'd0, 1'b0},
         '{32'sd100,       1'b0, 1'b0, 19'd0, 1'b0},
         '{-32'sd100,      1'b0, 1'b0, 19'd0, 1'b0},
         '{32'sd100,       1'b1, 1'b0, 19'd0, 1'b0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         offer_value(plan[i].value, plan[i].last, plan[i].known,
                     plan[i].inversions, plan[i].overflow);

      send_short_runs(200);
      send_full_run();
      send_short_runs(60);
      idle_on = 1'b0;
      send_short_runs(100);
      req_if.valid <= 1'b0;

      while (pending_totals.size() != 0) @(posedge clock);
      // leave room for a stray total to surface through the full cell row
      repeat (CELLS + 16) @(posedge clock);

      $display("summary: %0d items sent incl. one capacity overrun, %0d totals checked",
               items_sent, totals_seen);
      $display("summary: %0d mismatches", fail_count);
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
